// ===== hw/rtl/slbc_pkg.sv =====
// Package for the status-light blink classifier: link status codes, timing
// windows, configuration defaults and the records passed between its stages.
// No dependencies; every other file of the block imports it.
package slbc_pkg;

    typedef enum logic [1:0] {
        STATUS_OFF       = 2'd0,
        STATUS_NOT_REG   = 2'd1,
        STATUS_REG       = 2'd2,
        STATUS_CONNECTED = 2'd3
    } link_status_t;

    typedef enum logic [1:0] {
        CFG_OFF_TIMEOUT    = 2'd0,
        CFG_REPORT_TIMEOUT = 2'd1,
        CFG_MIN_HIGH       = 2'd2
    } cfg_index_t;

    localparam int unsigned US_PER_MS = 1000;

    localparam logic [31:0] OFF_TIMEOUT_RESET    = 32'd5000000;
    localparam logic [31:0] REPORT_TIMEOUT_RESET = 32'd60000000;
    localparam logic [15:0] MIN_HIGH_RESET       = 16'd58;

    // A millisecond threshold (m + 1) * 1000 fits in this many bits for any m.
    localparam int unsigned THR_W = 26;

    localparam logic [THR_W-1:0] MIN_HIGH_THR_RESET =
        THR_W'((MIN_HIGH_RESET + 1) * US_PER_MS);

    // Low-width windows, exclusive in milliseconds, turned into microsecond
    // bounds: floor(us / 1000) > lo  <=>  us >= (lo + 1) * 1000, and
    // floor(us / 1000) < hi  <=>  us < hi * 1000.
    localparam logic [31:0] CONN_LO_US   = 32'((270 + 1) * US_PER_MS);
    localparam logic [31:0] CONN_HI_US   = 32'(330 * US_PER_MS);
    localparam logic [31:0] NOTREG_LO_US = 32'((720 + 1) * US_PER_MS);
    localparam logic [31:0] NOTREG_HI_US = 32'(880 * US_PER_MS);
    localparam logic [31:0] REG_LO_US    = 32'((2700 + 1) * US_PER_MS);
    localparam logic [31:0] REG_HI_US    = 32'(3300 * US_PER_MS);

    // Saturation point of a 16-bit millisecond width.
    localparam logic [31:0] SAT_US = 32'(65536 * US_PER_MS);

    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x.
    localparam logic [31:0] DIV_MAGIC = 32'h10624DD3;
    localparam int unsigned DIV_SHIFT = 38;

    typedef struct packed {
        logic [31:0]      off_timeout_us;
        logic [31:0]      report_timeout_us;
        logic [THR_W-1:0] min_high_us;
        logic             high_check_en;
    } cfg_t;

    typedef struct packed {
        link_status_t link_status;
        logic [31:0]  high_us;
        logic [31:0]  low_us;
        logic         from_timeout;
    } report_t;

endpackage

// ===== hw/rtl/slbc_if.sv =====
// Request channels of the blink classifier: pin and tick events in, status
// reports out. Depends on slbc_pkg for the link status type.
interface slbc_event_if ();
    logic        valid;
    logic        ready;
    logic        operation;
    logic        pin_level;
    logic [31:0] now_us;

    modport source (output valid, operation, pin_level, now_us, input ready);
    modport sink (input valid, operation, pin_level, now_us, output ready);
endinterface

interface slbc_report_if import slbc_pkg::*; ();
    logic         valid;
    logic         ready;
    link_status_t link_status;
    logic [15:0]  high_width_ms;
    logic [15:0]  low_width_ms;
    logic         from_timeout;

    modport source (output valid, link_status, high_width_ms, low_width_ms, from_timeout,
                    input ready);
    modport sink (input valid, link_status, high_width_ms, low_width_ms, from_timeout,
                  output ready);
endinterface

// ===== hw/rtl/status_led_blink_classifier.sv =====
// Top level of the status-light blink classifier: configuration registers,
// event stage and millisecond output stage. Depends on slbc_pkg and slbc_if.

// The block decodes the blink pattern of a modem status light. Each request
// on event_in is either a pin edge (operation 0, pin_level giving the level
// after the edge) or a time tick (operation 1), both stamped with a free
// running, wrapping microsecond counter. An edge updates the measured high
// or low width, clears it and forces the status off when the last falling
// edge is older than the off timeout, and classifies the status: off unless
// the high width is above the minimum, else from the low width: connected,
// not registered or registered. A report leaves on report_out when the
// status changes, or again after the report timeout while the status is not
// off. A tick checks the off timer armed by the last falling edge and, when
// it has run out, sends a zeroed off report with from_timeout set. Each
// event request or tick may produce at most one report. The block takes one
// request per clock cycle, sustained; the event stage registers a report at
// the edge that accepts its request, and the output stage, which turns
// microseconds into saturated milliseconds with a reciprocal multiply, loads
// it into its own register, which drives report_out, once it has room. Each
// stage buffers one report while the sink stalls; event_in is held off only
// once both stages hold a report that the sink has not taken.
// Configuration writes (off timeout, report timeout, minimum high width, in
// that index order) take effect on the next clock edge and belong in idle
// periods; writes to an unused index are ignored.
module status_led_blink_classifier import slbc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    slbc_event_if.sink    event_in,
    slbc_report_if.source report_out
);

    cfg_t    cfg;
    logic    rep_valid;
    logic    rep_ready;
    report_t rep;

    // Register file; the minimum high width is stored as a microsecond
    // threshold so the event stage needs no division.
    slbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Event stage: all timing state lives here and is updated at the edge
    // that accepts the request, so the next request sees it at once.
    slbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .event_in  (event_in),
        .rep_valid (rep_valid),
        .rep       (rep),
        .rep_ready (rep_ready)
    );

    // Output stage: microsecond widths to saturated milliseconds.
    slbc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .rep_valid  (rep_valid),
        .rep        (rep),
        .rep_ready  (rep_ready),
        .report_out (report_out)
    );

endmodule

// ===== hw/rtl/slbc_cfg.sv =====
// Configuration registers of the blink classifier, with the minimum high
// width precomputed as a microsecond threshold. Depends on slbc_pkg.
module slbc_cfg import slbc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    logic [31:0]      off_timeout_reg;
    logic [31:0]      report_timeout_reg;
    logic [THR_W-1:0] min_high_thr_reg;
    logic             high_check_en_reg;
    logic [16:0]      min_high_p1;
    logic [THR_W-1:0] min_high_thr_next;

    // A high width can only exceed the minimum when the minimum is below
    // the saturation value.
    assign min_high_p1       = {1'b0, cfg_data[15:0]} + 17'd1;
    assign min_high_thr_next = THR_W'(min_high_p1) * THR_W'(US_PER_MS);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            off_timeout_reg    <= OFF_TIMEOUT_RESET;
            report_timeout_reg <= REPORT_TIMEOUT_RESET;
            min_high_thr_reg   <= MIN_HIGH_THR_RESET;
            high_check_en_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFF_TIMEOUT:
                begin
                    off_timeout_reg <= cfg_data;
                end
                CFG_REPORT_TIMEOUT:
                begin
                    report_timeout_reg <= cfg_data;
                end
                CFG_MIN_HIGH:
                begin
                    min_high_thr_reg  <= min_high_thr_next;
                    high_check_en_reg <= (cfg_data[15:0] != 16'hFFFF);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.off_timeout_us    = off_timeout_reg;
    assign cfg.report_timeout_us = report_timeout_reg;
    assign cfg.min_high_us       = min_high_thr_reg;
    assign cfg.high_check_en     = high_check_en_reg;

endmodule

// ===== hw/rtl/slbc_core.sv =====
// Event stage of the blink classifier: edge timing state, off timer,
// classification and the report decision, registered into one report slot.
// Depends on slbc_pkg and slbc_if.
module slbc_core import slbc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    slbc_event_if.sink   event_in,
    output logic         rep_valid,
    output report_t      rep,
    input  logic         rep_ready
);

    logic [31:0]  rise_time_reg, fall_time_reg, last_fall_reg, last_report_reg;
    logic [31:0]  high_us_reg, low_us_reg;
    link_status_t current_reg, reported_reg;
    logic         armed_reg;
    logic         rep_valid_reg;
    logic         rep_valid_next;
    report_t      rep_reg;

    logic         accept;
    logic         is_tick;
    logic [31:0]  since_fall;
    logic         fresh;
    logic [31:0]  high_us_next, low_us_next;
    logic         high_ok;
    link_status_t status_base, status_next, reported_base;
    logic         changed, repeat_due, edge_emit, expire;

    assign event_in.ready = !rep_valid_reg || rep_ready;
    assign accept         = event_in.valid && event_in.ready;
    assign is_tick        = event_in.operation;

    assign since_fall = event_in.now_us - last_fall_reg;
    assign fresh      = since_fall < cfg.off_timeout_us;
    assign expire     = armed_reg && !fresh;

    always_comb
    begin
        high_us_next = high_us_reg;
        low_us_next  = low_us_reg;
        if (event_in.pin_level)
            low_us_next = fresh ? (event_in.now_us - fall_time_reg) : 32'd0;
        else
            high_us_next = fresh ? (event_in.now_us - rise_time_reg) : 32'd0;
    end

    assign status_base   = fresh ? current_reg : STATUS_OFF;
    assign reported_base = fresh ? reported_reg : STATUS_OFF;
    assign high_ok       = cfg.high_check_en && (high_us_next >= 32'(cfg.min_high_us));

    always_comb
    begin
        status_next = status_base;
        if (!high_ok)
            status_next = STATUS_OFF;
        else if (low_us_next >= CONN_LO_US && low_us_next < CONN_HI_US)
            status_next = STATUS_CONNECTED;
        else if (low_us_next >= NOTREG_LO_US && low_us_next < NOTREG_HI_US)
            status_next = STATUS_NOT_REG;
        else if (low_us_next >= REG_LO_US && low_us_next < REG_HI_US)
            status_next = STATUS_REG;
    end

    assign changed    = status_next != reported_base;
    assign repeat_due = ((event_in.now_us - last_report_reg) > cfg.report_timeout_us)
                        && (status_next != STATUS_OFF);
    assign edge_emit  = changed || repeat_due;

    // The slot empties when the output stage takes it and refills when the
    // accepted request produces a report.
    always_comb
    begin
        rep_valid_next = rep_valid_reg && !rep_ready;
        if (accept && is_tick && expire)
            rep_valid_next = 1'b1;
        else if (accept && !is_tick && edge_emit)
            rep_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            rise_time_reg   <= '0;
            fall_time_reg   <= '0;
            last_fall_reg   <= '0;
            last_report_reg <= '0;
            high_us_reg     <= '0;
            low_us_reg      <= '0;
            current_reg     <= STATUS_OFF;
            reported_reg    <= STATUS_OFF;
            armed_reg       <= 1'b0;
            rep_valid_reg   <= 1'b0;
        end
        else
        begin
            rep_valid_reg <= rep_valid_next;
            if (accept && is_tick)
            begin
                if (expire)
                    armed_reg <= 1'b0;
            end
            else if (accept)
            begin
                high_us_reg  <= high_us_next;
                low_us_reg   <= low_us_next;
                current_reg  <= status_next;
                reported_reg <= status_next;
                if (event_in.pin_level)
                    rise_time_reg <= event_in.now_us;
                else
                begin
                    fall_time_reg <= event_in.now_us;
                    last_fall_reg <= event_in.now_us;
                    armed_reg     <= 1'b1;
                end
                if (edge_emit)
                    last_report_reg <= event_in.now_us;
            end
        end
    end

    // Report payload; only loaded when a report is actually produced.
    always_ff @(posedge clk) begin
        if (accept && is_tick && expire)
        begin
            rep_reg.link_status  <= STATUS_OFF;
            rep_reg.high_us      <= '0;
            rep_reg.low_us       <= '0;
            rep_reg.from_timeout <= 1'b1;
        end
        else if (accept && !is_tick && edge_emit)
        begin
            rep_reg.link_status  <= status_next;
            rep_reg.high_us      <= high_us_next;
            rep_reg.low_us       <= low_us_next;
            rep_reg.from_timeout <= 1'b0;
        end
    end

    assign rep_valid = rep_valid_reg;
    assign rep       = rep_reg;

endmodule

// ===== hw/rtl/slbc_out.sv =====
// Output stage of the blink classifier: converts the microsecond widths of a
// report to saturated milliseconds and holds it for the sink. Depends on
// slbc_pkg and slbc_if.
module slbc_out import slbc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rep_valid,
    input  report_t       rep,
    output logic          rep_ready,
    slbc_report_if.source report_out
);

    logic         out_valid_reg;
    link_status_t status_reg;
    logic [15:0]  high_ms_reg, low_ms_reg;
    logic         from_timeout_reg;
    logic         take;
    logic [63:0]  high_prod, low_prod;
    logic [15:0]  high_ms_next, low_ms_next;

    assign rep_ready = !out_valid_reg || report_out.ready;
    assign take      = rep_valid && rep_ready;

    // Division by 1000 as a multiply by the reciprocal.
    assign high_prod    = 64'(rep.high_us) * 64'(DIV_MAGIC);
    assign low_prod     = 64'(rep.low_us) * 64'(DIV_MAGIC);
    assign high_ms_next = (rep.high_us >= SAT_US) ? 16'hFFFF
                                                  : high_prod[DIV_SHIFT+15:DIV_SHIFT];
    assign low_ms_next  = (rep.low_us >= SAT_US) ? 16'hFFFF
                                                 : low_prod[DIV_SHIFT+15:DIV_SHIFT];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rep_ready)
            out_valid_reg <= rep_valid;
    end

    always_ff @(posedge clk) begin
        if (take)
        begin
            status_reg       <= rep.link_status;
            high_ms_reg      <= high_ms_next;
            low_ms_reg       <= low_ms_next;
            from_timeout_reg <= rep.from_timeout;
        end
    end

    assign report_out.valid         = out_valid_reg;
    assign report_out.link_status   = status_reg;
    assign report_out.high_width_ms = high_ms_reg;
    assign report_out.low_width_ms  = low_ms_reg;
    assign report_out.from_timeout  = from_timeout_reg;

endmodule

// ===== test/status_led_blink_classifier_test.sv =====
// Self-checking testbench for status_led_blink_classifier: pin edge and tick requests in,
// status reports out, each report checked field by field against a built-in predictor.
// Depends on slbc_pkg, the slbc_event_if / slbc_report_if interfaces and the block's RTL.
module status_led_blink_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slbc_pkg::*;

    localparam real CLK_PERIOD_NS    = 12.0;
    localparam int  RESET_CYCLES     = 5;
    // Two pipeline stages plus generous slack for requests that make no report.
    localparam int  SETTLE_CYCLES    = 10;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam int  PHASES           = 7;
    localparam int  ITEMS_PER_PHASE  = 285;
    localparam int  LIMIT_CYCLES     = 400000;
    localparam int  MAX_PRINTS       = 50;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    localparam logic PIN_FALL = 1'b0;
    localparam logic PIN_RISE = 1'b1;

    // Index 3 is not a register; writes to it must change nothing.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // Exclusive low-width windows in milliseconds.
    localparam int unsigned CONN_LO_MS   = 270;
    localparam int unsigned CONN_HI_MS   = 330;
    localparam int unsigned NOTREG_LO_MS = 720;
    localparam int unsigned NOTREG_HI_MS = 880;
    localparam int unsigned REG_LO_MS    = 2700;
    localparam int unsigned REG_HI_MS    = 3300;
    localparam int unsigned MS_US        = 1000;

    typedef struct packed {
        logic        operation;
        logic        pin_level;
        logic [31:0] now_us;
    } blink_event_t;

    typedef struct packed {
        link_status_t link_status;
        logic [15:0]  high_width_ms;
        logic [15:0]  low_width_ms;
        logic         from_timeout;
    } status_report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    slbc_event_if  ev ();
    slbc_report_if rep ();

    status_led_blink_classifier uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .event_in   (ev),
        .report_out (rep)
    );

    // Requests waiting to be offered, and reports the block still owes us.
    blink_event_t   pending_events[$];
    status_report_t expected_reports[$];

    int unsigned events_queued   = 0;
    int unsigned events_accepted = 0;
    int unsigned error_count     = 0;

    // Idling percentages per phase; the long hold-off is its own counter.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    logic        hold_start     = 1'b0;

    // High when the request on the event channel was taken at the last rising edge.
    logic        event_taken    = 1'b0;

    // Timestamp generator state. The clock wraps at 2^32 like the real counter.
    logic [31:0] clock_us      = 32'd0;
    logic [31:0] gen_last_fall = 32'd0;

    // Predictor copy of the configuration registers.
    logic [31:0] off_timeout_cfg    = OFF_TIMEOUT_RESET;
    logic [31:0] report_timeout_cfg = REPORT_TIMEOUT_RESET;
    logic [15:0] min_high_cfg       = MIN_HIGH_RESET;

    // Predictor copy of the decoder state.
    logic [31:0]  rise_stamp   = 32'd0;
    logic [31:0]  fall_stamp   = 32'd0;
    logic [31:0]  report_stamp = 32'd0;
    logic [15:0]  high_ms      = 16'd0;
    logic [15:0]  low_ms       = 16'd0;
    link_status_t status_now   = STATUS_OFF;
    link_status_t status_sent  = STATUS_OFF;
    logic         timer_armed  = 1'b0;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2.0) clk = ~clk;
    end

    // Whole milliseconds of an elapsed time, saturated to 16 bits.
    function automatic logic [15:0] ms_width(input logic [31:0] elapsed_us);
        logic [31:0] whole_ms;
        whole_ms = elapsed_us / MS_US;
        if (whole_ms > 32'd65535)
            return 16'hFFFF;
        return whole_ms[15:0];
    endfunction

    // Updates the predicted decoder state for one accepted request and queues
    // the report it should cause, if any.
    task automatic predict_event(input logic op, input logic level, input logic [31:0] now);
        logic [31:0] since_fall;
        logic [31:0] since_report;
        logic        fresh;
        since_fall = now - fall_stamp;
        if (op == OP_TICK) begin
            // The one-shot off timer fires once per falling edge.
            if (timer_armed && since_fall >= off_timeout_cfg) begin
                timer_armed = 1'b0;
                expected_reports.push_back('{STATUS_OFF, 16'd0, 16'd0, 1'b1});
            end
        end
        else begin
            fresh = since_fall < off_timeout_cfg;
            if (level == PIN_RISE) begin
                rise_stamp = now;
                low_ms     = fresh ? ms_width(now - fall_stamp) : 16'd0;
            end
            else begin
                high_ms     = fresh ? ms_width(now - rise_stamp) : 16'd0;
                fall_stamp  = now;
                timer_armed = 1'b1;
            end
            // A stale edge forgets what was reported, so a later change is always seen.
            if (!fresh) begin
                status_now  = STATUS_OFF;
                status_sent = STATUS_OFF;
            end
            if (high_ms > min_high_cfg) begin
                if (low_ms > CONN_LO_MS && low_ms < CONN_HI_MS)
                    status_now = STATUS_CONNECTED;
                else if (low_ms > NOTREG_LO_MS && low_ms < NOTREG_HI_MS)
                    status_now = STATUS_NOT_REG;
                else if (low_ms > REG_LO_MS && low_ms < REG_HI_MS)
                    status_now = STATUS_REG;
            end
            else begin
                status_now = STATUS_OFF;
            end
            since_report = now - report_stamp;
            if (status_now != status_sent) begin
                report_stamp = now;
                status_sent  = status_now;
                expected_reports.push_back('{status_now, high_ms, low_ms, 1'b0});
            end
            else if (since_report > report_timeout_cfg && status_now != STATUS_OFF) begin
                report_stamp = now;
                expected_reports.push_back('{status_now, high_ms, low_ms, 1'b0});
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch %0d at %0t ns: %s", error_count, $time, what);
    endtask

    // Register writes happen only while the block is idle, so the predictor
    // copy can be updated right away.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_OFF_TIMEOUT:    off_timeout_cfg    = value;
            CFG_REPORT_TIMEOUT: report_timeout_cfg = value;
            CFG_MIN_HIGH:       min_high_cfg       = value[15:0];
            default: ;
        endcase
    endtask

    // Changed just after a rising edge so the negedge drivers see a stable value.
    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic queue_event(input logic op, input logic level);
        pending_events.push_back('{operation: op, pin_level: level, now_us: clock_us});
        events_queued++;
        if (op == OP_EDGE && level == PIN_FALL)
            gen_last_fall = clock_us;
    endtask

    task automatic queue_after(input logic op, input logic level, input logic [31:0] delta_us);
        clock_us += delta_us;
        queue_event(op, level);
    endtask

    // An edge after a gap; now and then a tick lands somewhere inside the gap.
    task automatic queue_edge_with_tick(input logic level, input int unsigned gap_us);
        int unsigned split;
        if ($urandom_range(4, 0) == 0) begin
            split = $urandom_range(gap_us, 0);
            queue_after(OP_TICK, 1'($urandom_range(1, 0)), split);
            gap_us -= split;
        end
        queue_after(OP_EDGE, level, gap_us);
    endtask

    // Waits until every request is in and every report is out, then lets
    // requests that make no report drain through both stages.
    task automatic settle();
        while (events_accepted != events_queued || expected_reports.size() != 0)
            @(negedge clk);
        @(posedge clk);
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: a request stays on the channel until it is taken; a new one
    // is only put up (or an idle cycle inserted) once the old one is gone.
    always @(negedge clk) begin : drive_events
        blink_event_t next_event;
        if (!rst_n) begin
            ev.valid <= 1'b0;
        end
        else if (!ev.valid || event_taken) begin
            if (pending_events.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_event   = pending_events.pop_front();
                ev.valid     <= 1'b1;
                ev.operation <= next_event.operation;
                ev.pin_level <= next_event.pin_level;
                ev.now_us    <= next_event.now_us;
            end
            else begin
                ev.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off that fills the pipeline.
    always @(negedge clk) begin
        if (!rst_n)
            rep.ready <= 1'b0;
        else
            rep.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (hold_start)
            hold_left <= LONG_HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Both handshakes are sampled at the rising edge. A report is checked
    // before the request of the same edge is predicted; it cannot belong to it.
    always @(posedge clk or negedge rst_n) begin : check_and_predict
        status_report_t want;
        if (!rst_n) begin
            event_taken <= 1'b0;
        end
        else begin
            if (rep.valid && rep.ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected report status %0d hi %0d lo %0d tmo %0d",
                        rep.link_status, rep.high_width_ms, rep.low_width_ms,
                        rep.from_timeout));
                end
                else begin
                    want = expected_reports.pop_front();
                    if (rep.link_status !== want.link_status)
                        report_mismatch($sformatf("link_status %0d, expected %0d",
                            rep.link_status, want.link_status));
                    if (rep.high_width_ms !== want.high_width_ms)
                        report_mismatch($sformatf("high_width_ms %0d, expected %0d",
                            rep.high_width_ms, want.high_width_ms));
                    if (rep.low_width_ms !== want.low_width_ms)
                        report_mismatch($sformatf("low_width_ms %0d, expected %0d",
                            rep.low_width_ms, want.low_width_ms));
                    if (rep.from_timeout !== want.from_timeout)
                        report_mismatch($sformatf("from_timeout %0d, expected %0d",
                            rep.from_timeout, want.from_timeout));
                end
            end
            if (ev.valid && ev.ready) begin
                predict_event(ev.operation, ev.pin_level, ev.now_us);
                events_accepted++;
            end
            event_taken <= ev.valid && ev.ready;
        end
    end

    initial begin : stimulus
        int unsigned phase_end;
        int unsigned low_width_ms;
        int unsigned high_width_ms;
        int unsigned pick;
        logic [31:0] off_value;
        logic [31:0] report_value;
        logic [31:0] min_high_value;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_OFF_TIMEOUT;
        cfg_data     = 32'd0;
        ev.valid     = 1'b0;
        ev.operation = OP_EDGE;
        ev.pin_level = PIN_FALL;
        ev.now_us    = 32'd0;
        rep.ready    = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // A write to the unused index must leave the reset values in place,
        // which the directed part below depends on.
        write_register(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        set_idling(0, 0);

        // Directed part, reset configuration (5 s off, 60 s repeat, 58 ms high).
        clock_us = 32'd0;
        queue_after(OP_TICK, PIN_RISE, 0);          // tick with the timer never armed
        queue_after(OP_EDGE, PIN_RISE, 1000);
        queue_after(OP_EDGE, PIN_FALL, 58999);      // high width equal to the minimum
        queue_after(OP_EDGE, PIN_RISE, 270999);     // low width on the lower connected bound
        queue_after(OP_EDGE, PIN_FALL, 59000);      // high width just above the minimum
        queue_after(OP_EDGE, PIN_RISE, 271000);     // first width inside connected
        queue_after(OP_EDGE, PIN_FALL, 59000);
        queue_after(OP_EDGE, PIN_RISE, 329999);     // last width inside connected
        queue_after(OP_EDGE, PIN_FALL, 100000);
        queue_after(OP_EDGE, PIN_RISE, 330000);     // upper bound: status is kept
        queue_after(OP_EDGE, PIN_FALL, 100000);
        queue_after(OP_EDGE, PIN_RISE, 721000);     // not registered
        queue_after(OP_EDGE, PIN_FALL, 100000);
        queue_after(OP_EDGE, PIN_RISE, 2701000);    // registered
        queue_after(OP_EDGE, PIN_FALL, 100000);
        queue_after(OP_EDGE, PIN_RISE, 3299999);
        queue_after(OP_TICK, PIN_FALL, 1700000);    // one microsecond short of the timeout
        queue_after(OP_TICK, PIN_FALL, 1);          // timer expires exactly on the timeout
        queue_after(OP_TICK, PIN_RISE, 1);          // already disarmed
        queue_after(OP_EDGE, PIN_FALL, 10000000);   // stale edge clears the width
        // Widths measured across the wrap of the microsecond counter.
        clock_us = 32'hFFFF_FFFF - 32'd200000;
        queue_event(OP_EDGE, PIN_FALL);
        queue_after(OP_EDGE, PIN_RISE, 200000);     // lands on the all-ones timestamp
        queue_after(OP_EDGE, PIN_FALL, 100001);
        queue_after(OP_EDGE, PIN_RISE, 800000);
        settle();

        // Random phases, each with its own register settings and idling mix.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    off_value      = OFF_TIMEOUT_RESET;
                    report_value   = REPORT_TIMEOUT_RESET;
                    min_high_value = 32'(MIN_HIGH_RESET);
                end
                1: begin
                    // Short repeat interval so unchanged states get reported again.
                    off_value      = OFF_TIMEOUT_RESET;
                    report_value   = 32'd3000000;
                    min_high_value = 32'd58;
                end
                2: begin
                    // Almost every edge is stale and every report repeats.
                    off_value      = 32'd1;
                    report_value   = 32'd1;
                    min_high_value = 32'd0;
                end
                3: begin
                    off_value      = 32'hFFFF_FFFF;
                    report_value   = 32'hFFFF_FFFF;
                    min_high_value = 32'd65535;
                end
                4: begin
                    // Reports on nearly every edge; this is the phase that
                    // gets the long receiver hold-off.
                    off_value      = 32'hFFFF_FFFF;
                    report_value   = 32'd1;
                    min_high_value = 32'd100;
                end
                5: begin
                    off_value      = $urandom_range(8000000, 500000);
                    report_value   = $urandom_range(20000000, 1000000);
                    min_high_value = $urandom_range(300, 0);
                end
                default: begin
                    // Upper data bits of the 16-bit register must be dropped.
                    off_value      = $urandom_range(32'hFFFF_FFFF, 1);
                    report_value   = $urandom_range(32'hFFFF_FFFF, 1);
                    min_high_value = {16'($urandom), 16'($urandom_range(400, 0))};
                end
            endcase
            write_register(CFG_OFF_TIMEOUT, off_value);
            write_register(CFG_REPORT_TIMEOUT, report_value);
            write_register(CFG_MIN_HIGH, min_high_value);

            case (phase % 4)
                0:       set_idling(0, 0);
                1:       set_idling(58, 0);
                2:       set_idling(0, 58);
                default: set_idling(6, 6);
            endcase

            if (phase == 4) begin
                @(negedge clk);
                hold_start = 1'b1;
                @(negedge clk);
                hold_start = 1'b0;
            end

            phase_end = events_queued + ITEMS_PER_PHASE;
            while (events_queued < phase_end) begin
                if ($urandom_range(99, 0) < 80) begin
                    // One blink: a low gap ended by a rise, a high gap ended by a fall.
                    pick = $urandom_range(9, 0);
                    case (pick)
                        0, 1:    low_width_ms = $urandom_range(CONN_HI_MS - 1, CONN_LO_MS + 1);
                        2, 3:    low_width_ms = $urandom_range(NOTREG_HI_MS - 1,
                                                               NOTREG_LO_MS + 1);
                        4, 5:    low_width_ms = $urandom_range(REG_HI_MS - 1, REG_LO_MS + 1);
                        6: begin
                            case ($urandom_range(5, 0))
                                0:       low_width_ms = CONN_LO_MS;
                                1:       low_width_ms = CONN_HI_MS;
                                2:       low_width_ms = NOTREG_LO_MS;
                                3:       low_width_ms = NOTREG_HI_MS;
                                4:       low_width_ms = REG_LO_MS;
                                default: low_width_ms = REG_HI_MS;
                            endcase
                        end
                        7:       low_width_ms = $urandom_range(100, 0);
                        8:       low_width_ms = $urandom_range(4000, 0);
                        default: low_width_ms = $urandom_range(70000, 5000);
                    endcase
                    queue_edge_with_tick(PIN_RISE,
                        low_width_ms * MS_US + $urandom_range(MS_US - 1, 0));

                    // Mostly above the minimum high width, some right on it,
                    // some below, and a few long enough to saturate.
                    pick = $urandom_range(99, 0);
                    if (pick < 70)
                        high_width_ms = min_high_cfg + 1 + $urandom_range(300, 0);
                    else if (pick < 85)
                        high_width_ms = min_high_cfg + $urandom_range(1, 0);
                    else if (pick < 95)
                        high_width_ms = $urandom_range(min_high_cfg, 0);
                    else
                        high_width_ms = $urandom_range(70000, 0);
                    queue_edge_with_tick(PIN_FALL,
                        high_width_ms * MS_US + $urandom_range(MS_US - 1, 0));

                    // Sometimes the light goes dark: a tick right around the off timeout.
                    if ($urandom_range(9, 0) == 0) begin
                        clock_us = gen_last_fall + off_timeout_cfg - 1 + $urandom_range(2, 0);
                        queue_event(OP_TICK, 1'($urandom_range(1, 0)));
                    end
                end
                else begin
                    // Noise: any request at small, large or arbitrary jumps in time,
                    // including repeated levels and jumps to the off-timeout edge.
                    case ($urandom_range(3, 0))
                        0:       clock_us += $urandom_range(2000, 0);
                        1:       clock_us += $urandom_range(6000000, 0);
                        2:       clock_us = $urandom;
                        default: clock_us = gen_last_fall + off_timeout_cfg - 1
                                            + $urandom_range(2, 0);
                    endcase
                    queue_event(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                end
            end
            settle();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
